// File: src/grid_maze_dfs_solver_macros.svh
// Assertion macros for the maze solver
`ifndef GRID_MAZE_DFS_SOLVER_MACROS_SVH
`define GRID_MAZE_DFS_SOLVER_MACROS_SVH
`define GMD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: src/gmd_pkg.sv
// Package for the maze solver: types, codes and sizes
package gmd_pkg;
  localparam int MaxCols = 64;
  localparam int MaxRows = 64;
  localparam int ColW = $clog2(MaxCols);
  localparam int RowW = $clog2(MaxRows);
  localparam int CellW = ColW + RowW;
  localparam int NCells = MaxCols * MaxRows;
  localparam int SpW = CellW + 1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0, OP_SOLVE = 2'd1, OP_READ = 2'd2, OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CELL_OPEN = 2'd0, CELL_WALL = 2'd1, CELL_SEEN = 2'd2, CELL_ROUTE = 2'd3
  } cell_e;

  typedef enum logic [1:0] {
    REG_WIDTH = 2'd0, REG_HEIGHT = 2'd1, REG_EXIT_COL = 2'd2, REG_EXIT_ROW = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_PROBE, ST_CHECK, ST_TOP, ST_NEXT,
    ST_UNWIND, ST_UNWIND_WR, ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
    logic       wall_bit;
  } in_t;

  typedef struct packed {
    logic       path_found;
    logic [1:0] cell_state;
  } out_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [2:0]      dir;
  } frame_t;
endpackage

// File: src/grid_maze_dfs_solver.sv
// Maze solver top level: grid RAM, stack RAM and search sequencer.
// After reset all 4096 grid cells are swept to wall, and no item is taken
// meanwhile. A solve probes each neighbour and rejects it without a grid read
// when it is off the plane or outside the grid or the stack is full, or on its
// grid read when it is not open, else enters it; it backtracks by popping the
// stack, and on reaching the exit it marks the route by unwinding the stacked
// cells. The result sits in its own output register, so a waiting result
// stalls the next item only in its final state.
module grid_maze_dfs_solver
  import gmd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);
  `include "grid_maze_dfs_solver_macros.svh"

  state_e st_q, st_d;
  logic [6:0] width_q, height_q;
  logic [5:0] exit_col_q, exit_row_q;
  logic [SpW-1:0] sp_q, sp_d;
  logic [CellW-1:0] clr_q, clr_d;
  frame_t top_q, top_d;
  logic [ColW-1:0] pc_q, pc_d;
  logic [RowW-1:0] pr_q, pr_d;
  logic pin_q, pin_d;
  logic pf_q, pf_d;
  in_t req_q, req_d;
  out_t res_q, res_d;
  logic ov_q, ov_d;

  logic g_we, s_we;
  logic [CellW-1:0] g_addr, s_addr;
  logic [1:0] g_wd, g_rd;
  frame_t s_wd, s_rd;

  gmd_ram #(.Width(2), .Depth(NCells)) u_grid (
    .clk_i, .we_i(g_we), .addr_i(g_addr), .wdata_i(g_wd), .rdata_o(g_rd));
  gmd_ram #(.Width($bits(frame_t)), .Depth(NCells)) u_stack (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wd), .rdata_o(s_rd));

  logic [8:0] ucols, urows;
  assign ucols = (width_q < 7'(MaxCols)) ? 9'(width_q) : 9'(MaxCols);
  assign urows = (height_q < 7'(MaxRows)) ? 9'(height_q) : 9'(MaxRows);

  function automatic logic [CellW-1:0] idx(logic [ColW-1:0] c, logic [RowW-1:0] r);
    return {r, c};
  endfunction

  logic req_in;
  assign req_in = (9'(req_q.cell_col) < ucols) && (9'(req_q.cell_row) < urows);

  // pin_q: probe coordinates lie on the full 64 x 64 plane
  logic is_exit;
  assign is_exit = pin_q && (6'(pc_q) == exit_col_q) && (6'(pr_q) == exit_row_q);
  logic p_in;
  assign p_in = pin_q && (9'(pc_q) < ucols) && (9'(pr_q) < urows);

  logic [SpW-1:0] sp_m1, sp_m2;
  assign sp_m1 = sp_q - SpW'(1);
  assign sp_m2 = sp_q - SpW'(2);

  // neighbour of top frame
  logic signed [9:0] nc, nr;
  always_comb begin
    nc = 10'(top_q.col);
    nr = 10'(top_q.row);
    case (top_q.dir[1:0])
      2'd0: nc = nc + 10'sd1;
      2'd1: nc = nc - 10'sd1;
      2'd2: nr = nr + 10'sd1;
      default: nr = nr - 10'sd1;
    endcase
  end

  logic nb_ok;
  assign nb_ok = (nc >= 10'sd0) && (nr >= 10'sd0) && (nc < 10'(MaxCols)) &&
                 (nr < 10'(MaxRows));

  assign in_ready_o = (st_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign out_data_o = res_q;

  always_comb begin
    st_d = st_q; sp_d = sp_q; clr_d = clr_q; top_d = top_q;
    pc_d = pc_q; pr_d = pr_q; pin_d = pin_q; pf_d = pf_q; req_d = req_q;
    res_d = res_q; ov_d = ov_q;
    g_we = 1'b0; g_addr = idx(pc_q, pr_q); g_wd = CELL_OPEN;
    s_we = 1'b0; s_addr = sp_q[CellW-1:0]; s_wd = top_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      ST_CLEAR: begin
        g_we = 1'b1; g_addr = clr_q; g_wd = CELL_WALL;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          req_d = in_data_i;
          pc_d = in_data_i.cell_col[ColW-1:0];
          pr_d = in_data_i.cell_row[RowW-1:0];
          pin_d = 1'b1;
          pf_d = 1'b0;
          sp_d = '0;
          case (in_data_i.opcode)
            OP_WRITE: st_d = ST_DONE;
            OP_SOLVE: st_d = ST_PROBE;
            OP_READ: st_d = ST_READ;
            default: st_d = ST_DONE;
          endcase
        end
      end
      ST_READ: st_d = ST_DONE; // grid read issued via g_addr
      ST_PROBE: begin
        if (is_exit) begin
          if (p_in) begin
            g_we = 1'b1; g_wd = CELL_ROUTE;
          end
          pf_d = 1'b1;
          st_d = (sp_q == '0) ? ST_DONE : ST_UNWIND;
        end else if (!p_in || sp_q >= SpW'(NCells)) begin
          st_d = (sp_q == '0) ? ST_DONE : ST_NEXT;
        end else begin
          st_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (g_rd == CELL_OPEN) begin
          g_we = 1'b1; g_wd = CELL_SEEN;
          s_we = 1'b1; s_wd = '{col: pc_q, row: pr_q, dir: 3'd0};
          top_d = '{col: pc_q, row: pr_q, dir: 3'd0};
          sp_d = sp_q + 1'b1;
          st_d = ST_NEXT;
        end else begin
          st_d = (sp_q == '0) ? ST_DONE : ST_NEXT;
        end
      end
      ST_NEXT: begin
        // top frame held in top_q
        if (top_q.dir[2]) begin
          sp_d = sp_m1;
          if (sp_q == SpW'(1)) begin
            st_d = ST_DONE;
          end else begin
            s_addr = sp_m2[CellW-1:0];
            st_d = ST_TOP;
          end
        end else begin
          s_we = 1'b1; s_addr = sp_m1[CellW-1:0];
          s_wd = top_q; s_wd.dir = top_q.dir + 3'd1;
          top_d.dir = top_q.dir + 3'd1;
          pc_d = nc[ColW-1:0];
          pr_d = nr[RowW-1:0];
          pin_d = nb_ok;
          st_d = ST_PROBE;
        end
      end
      ST_TOP: begin
        top_d = s_rd;
        st_d = ST_NEXT;
      end
      ST_UNWIND: begin
        s_addr = sp_m1[CellW-1:0];
        sp_d = sp_m1;
        st_d = ST_UNWIND_WR;
      end
      ST_UNWIND_WR: begin
        g_we = 1'b1; g_addr = idx(s_rd.col, s_rd.row); g_wd = CELL_ROUTE;
        if (sp_q == '0) begin
          st_d = ST_DONE;
        end else begin
          s_addr = sp_m1[CellW-1:0];
          sp_d = sp_m1;
        end
      end
      ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          if (req_q.opcode == OP_WRITE && req_in) begin
            g_we = 1'b1;
            g_addr = idx(req_q.cell_col[ColW-1:0], req_q.cell_row[RowW-1:0]);
            g_wd = req_q.wall_bit ? CELL_WALL : CELL_OPEN;
          end
          res_d.path_found = (req_q.opcode == OP_SOLVE) && pf_q;
          res_d.cell_state = (req_q.opcode != OP_READ) ? CELL_OPEN :
                             req_in ? g_rd : CELL_WALL;
          ov_d = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; sp_q <= '0; clr_q <= '0; ov_q <= 1'b0; pin_q <= 1'b0;
      width_q <= 7'd64; height_q <= 7'd64; exit_col_q <= 6'd63; exit_row_q <= 6'd0;
    end else begin
      st_q <= st_d; sp_q <= sp_d; clr_q <= clr_d; ov_q <= ov_d; pin_q <= pin_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_e'(cfg_index_i))
          REG_WIDTH: width_q <= cfg_data_i;
          REG_HEIGHT: height_q <= cfg_data_i;
          REG_EXIT_COL: exit_col_q <= cfg_data_i[5:0];
          REG_EXIT_ROW: exit_row_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d; pc_q <= pc_d; pr_q <= pr_d; pf_q <= pf_d;
    req_q <= req_d; res_q <= res_d;
  end

  `GMD_ASSERT_IMPL(a_no_accept_busy, in_valid_i && in_ready_o, st_q == ST_IDLE)
  `GMD_ASSERT_IMPL(a_sp_bound, 1'b1, sp_q <= SpW'(NCells))
  `GMD_ASSERT_NEXT(a_res_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
endmodule

// File: src/gmd_ram.sv
// Generic single-port synchronous RAM with registered read
module gmd_ram #(
  parameter int Width = 2,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
